>>> sv/dpt_pkg.sv
// ----------------------------------------------------------------------------
// dpt_pkg - shared types and constants for the dual prescaled timer
// Word formats, configuration register layout and the timer constants.
// ----------------------------------------------------------------------------
package dpt_pkg;

  localparam int unsigned AccW   = 19;
  localparam int unsigned SumW   = AccW + 1;
  localparam int unsigned CycW   = 3;
  localparam int unsigned StrW   = 16;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [SumW-1:0] TIMER_PERIOD = SumW'(262144);
  localparam logic [SumW-1:0] ACC_MAX      = SumW'(20'h7FFFF);
  localparam logic [6:0]      FIXED_STEP   = 7'd10;
  localparam logic [StrW-1:0] BASE_STRIDE  = 16'd40960;

  // register index: paddr[2]
  typedef enum logic {
    REG_RATE_SELECT  = 1'b0,
    REG_RELOAD_VALUE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] elapsed_cycles;
    logic       timers_halted;
    logic       variable_enable;
  } cmd_t;

  typedef struct packed {
    logic [3:0] fixed_count;
    logic [7:0] countdown;
    logic       expired;
  } res_t;

  typedef struct packed {
    logic [1:0] rate_select;
    logic [7:0] reload_value;
  } cfg_t;

  // variable timer stride by rate select
  function automatic logic [StrW-1:0] stride_of(input logic [1:0] sel);
    logic [StrW-1:0] s;
    case (sel)
      2'd0:    s = BASE_STRIDE;
      2'd1:    s = BASE_STRIDE >> 4;
      2'd2:    s = BASE_STRIDE >> 8;
      2'd3:    s = BASE_STRIDE >> 12;
      default: s = BASE_STRIDE;
    endcase
    return s;
  endfunction

endpackage

>>> sv/dpt_regs.sv
// ----------------------------------------------------------------------------
// dpt_regs - configuration registers
// APB-style register file holding rate select and reload value.
// ----------------------------------------------------------------------------
module dpt_regs import dpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t     regs;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign cfg    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr) begin
      case (idx)
        REG_RATE_SELECT:  regs.rate_select  <= pwdata[1:0];
        REG_RELOAD_VALUE: regs.reload_value <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RATE_SELECT:  prdata = {30'd0, regs.rate_select};
      REG_RELOAD_VALUE: prdata = {24'd0, regs.reload_value};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> sv/dpt_core.sv
// ----------------------------------------------------------------------------
// dpt_core - timer state and update logic
// Holds both accumulators, the fixed nibble and the countdown; computes the
// result word of the staged command and commits state on step.
// ----------------------------------------------------------------------------
module dpt_core import dpt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res
);

  logic [AccW-1:0] fixed_acc, fixed_acc_next;
  logic [AccW-1:0] var_acc, var_acc_next;
  logic [3:0]      nibble, nibble_next;
  logic [7:0]      count, count_next;
  logic            expired_next;

  logic [SumW-1:0] fsum, vsum, vsub;
  logic [AccW-1:0] vprod;

  always_comb begin
    fsum  = SumW'(fixed_acc) + SumW'(cmd.elapsed_cycles * FIXED_STEP);
    // widen before the multiply: seven times the base stride needs 19 bits
    vprod = AccW'(cmd.elapsed_cycles) * AccW'(stride_of(cfg.rate_select));
    vsum  = SumW'(var_acc) + SumW'(vprod);
    vsub  = (vsum >= TIMER_PERIOD) ? vsum - TIMER_PERIOD : vsum;

    fixed_acc_next = fixed_acc;
    nibble_next    = nibble;
    var_acc_next   = '0;
    count_next     = count;
    expired_next   = 1'b0;

    if (!cmd.timers_halted) begin
      if (fsum >= TIMER_PERIOD) begin
        fixed_acc_next = AccW'(fsum - TIMER_PERIOD);
        nibble_next    = nibble + 4'd1;
      end else begin
        fixed_acc_next = AccW'(fsum);
      end

      if (cmd.variable_enable) begin
        if (vsum >= TIMER_PERIOD) begin
          // underflow from zero: reload and flag
          if (count == 8'd0) begin
            count_next   = cfg.reload_value;
            expired_next = 1'b1;
          end else begin
            count_next = count - 8'd1;
          end
        end
        var_acc_next = (vsub > ACC_MAX) ? AccW'(ACC_MAX) : AccW'(vsub);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_acc <= '0;
      var_acc   <= '0;
      nibble    <= '0;
      count     <= '0;
    end else if (step) begin
      fixed_acc <= fixed_acc_next;
      var_acc   <= var_acc_next;
      nibble    <= nibble_next;
      count     <= count_next;
    end
  end

  assign res.fixed_count = nibble_next;
  assign res.countdown   = count_next;
  assign res.expired     = expired_next;

endmodule

>>> sv/dual_prescaled_timer.sv
// ----------------------------------------------------------------------------
// dual_prescaled_timer - fixed and variable prescaled timers
// Channel  | handshake           | word
// cmd      | cmd_valid/cmd_stall | cmd_t: elapsed_cycles, halted, enable
// res      | res_valid/res_stall | res_t: fixed_count, countdown, expired
// cfg      | APB psel/penable    | rate_select, reload_value
// One word per cycle sustained while res is not stalled; a word passes from
// the input register through the update logic into the result register.
// Reset clears the timer state, the registers and both valid flags.
// A stalled result holds the update stage; the input register then stalls
// cmd once it is full.
// ----------------------------------------------------------------------------
module dual_prescaled_timer import dpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  cmd_t             cmd,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  cmd_t stage;
  logic stage_valid;
  logic advance;
  res_t res_next;

  dpt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dpt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (stage),
    .cfg  (cfg),
    .res  (res_next)
  );

  assign advance   = stage_valid & (~res_valid | ~res_stall);
  assign cmd_stall = stage_valid & ~advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!cmd_stall) begin
      stage_valid <= cmd_valid;
    end
  end

  // hold the staged word while stalled
  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      stage <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  a_stall_needs_stage: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> stage_valid)
    else $error("cmd stalled with empty input register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced word produced no result");

  a_halt_no_expiry: assert property (@(posedge clk) disable iff (rst)
    (advance && stage.timers_halted) |=> !res.expired)
    else $error("expiry flagged while halted");

  a_disabled_no_expiry: assert property (@(posedge clk) disable iff (rst)
    (advance && !stage.variable_enable) |=> !res.expired)
    else $error("expiry flagged with variable timer disabled");

endmodule
